// ===== hdl/tthe_pkg.sv =====
package tthe_pkg;

    // angle and sample widths
    localparam int ANGLE_W   = 32;
    localparam int SAMPLE_W  = 16;
    localparam int KEEP_W    = 16;
    localparam int THR_W     = 15;
    localparam int MODE_W    = 2;
    localparam int TIME_W    = 16;
    localparam int STEP_W    = TIME_W - 1;

    // serial blend: difference, running partial product
    localparam int DIFF_W    = ANGLE_W + 1;
    localparam int FRAC_W    = ANGLE_W + 3;
    localparam int KCNT_W    = $clog2(KEEP_W + 1);

    // CORDIC datapath
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_W     = ANGLE_W + 3;
    localparam int ATAN_LEN     = 24;
    localparam int CCNT_W       = $clog2(ATAN_LEN + 1);

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(16384);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEER_MODE      = 2'd0,
        CFG_TOUCH_THRESHOLD = 2'd1,
        CFG_ACCEL_KEEP      = 2'd2,
        CFG_CAMERA_KEEP     = 2'd3
    } t_cfg_idx;

    localparam logic [MODE_W-1:0] MODE_KEYS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TOUCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TILT  = 2'd2;

    localparam logic FUNC_POINTER = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    localparam logic [1:0] ACT_DOWN = 2'd0;
    localparam logic [1:0] ACT_UP   = 2'd1;
    localparam logic [1:0] ACT_MOVE = 2'd2;

    // atan(2^-i) in 2^-32 turn
    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [CCNT_W-1:0] idx);
        logic [ANGLE_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/tthe_if.sv =====
interface tthe_in_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic [1:0]                          pointer_action;
    logic signed [tthe_pkg::SAMPLE_W-1:0] pointer_x;
    logic signed [tthe_pkg::SAMPLE_W-1:0] accel_x;
    logic signed [tthe_pkg::SAMPLE_W-1:0] accel_y;
    logic [tthe_pkg::TIME_W-1:0]         tick_time;
    logic                                key_left;
    logic                                key_right;

    modport source (output valid, func, pointer_action, pointer_x, accel_x, accel_y,
                    tick_time, key_left, key_right, input ready);
    modport sink   (input valid, func, pointer_action, pointer_x, accel_x, accel_y,
                    tick_time, key_left, key_right, output ready);
endinterface

interface tthe_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tthe_pkg::ANGLE_W-1:0] heading;
    logic signed [tthe_pkg::ANGLE_W-1:0] camera_angle;
    logic                                camera_valid;

    modport source (output valid, heading, camera_angle, camera_valid, input ready);
    modport sink   (input valid, heading, camera_angle, camera_valid, output ready);
endinterface

// ===== hdl/tilt_touch_heading_estimator.sv =====
// Heading estimator. Pointer words update the touch turn flags in touch mode.
// A tick outside tilt mode applies the heading step at accept, then runs the
// camera average in a bit-serial shift-add multiplier. A tilt tick runs the
// two accelerometer averages (skipped on the first tilt tick, which loads the
// samples), then the CORDIC, one rotation per cycle. A new word is taken only
// when the previous tick is finished; a finished result waits in the output
// register without blocking the input, but a result finished while that
// register is still full waits in the finish state and holds the input off.
module tilt_touch_heading_estimator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tthe_in_if.sink                           i_in,
    tthe_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [tthe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tthe_pkg::KEEP_W-1:0]       i_cfg_data
);
    import tthe_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_BLEND, ST_CORDIC, ST_FINISH} t_state;

    t_state r_state;

    logic [MODE_W-1:0]         r_mode;
    logic [THR_W-1:0]          r_thr;
    logic [KEEP_W-1:0]         r_akeep, r_ckeep;
    logic                      r_left, r_right, r_seeded, r_tilt;
    logic signed [ANGLE_W-1:0] r_avg_x, r_avg_y, r_heading, r_cam;
    logic                      r_out_valid, r_out_cv;
    logic signed [ANGLE_W-1:0] r_out_heading, r_out_cam;

    logic                      in_acc, tick_acc, ptr_acc, tilt;
    logic [STEP_W-1:0]         step;
    logic [TIME_W:0]           step_sum;
    logic signed [ANGLE_W-1:0] heading_keys;
    logic signed [THR_W+1:0]   px, thr_pos, thr_neg;
    logic                      bx_start, by_start, bx_done, by_done;
    logic signed [DIFF_W-1:0]  dx, dy;
    logic [KEEP_W-1:0]         keep_sel;
    logic signed [FRAC_W-1:0]  hx, hy;
    logic signed [ANGLE_W-1:0] new_avg_x, new_avg_y, new_cam;
    logic                      c_start, c_done;
    logic signed [ANGLE_W-1:0] c_x, c_y, c_angle;
    logic signed [ANGLE_W-1:0] sx_full, sy_full;
    logic                      out_free;

    assign in_acc   = i_in.valid && i_in.ready;
    assign tick_acc = in_acc && (i_in.func == FUNC_TICK);
    assign ptr_acc  = in_acc && (i_in.func == FUNC_POINTER);
    assign tilt     = (r_mode == MODE_TILT);
    assign out_free = !r_out_valid || o_out.ready;

    // heading step from keys and flags
    always_comb begin
        step_sum     = {1'b0, i_in.tick_time} + (TIME_W + 1)'(2);
        step         = step_sum[TIME_W:2];
        heading_keys = r_heading;
        if (i_in.key_left || r_left)
            heading_keys = heading_keys + ANGLE_W'(step);
        if (i_in.key_right || r_right)
            heading_keys = heading_keys - ANGLE_W'(step);
    end

    // touch zone comparisons
    always_comb begin
        px      = (THR_W + 2)'(i_in.pointer_x);
        thr_pos = (THR_W + 2)'({1'b0, r_thr});
        thr_neg = -thr_pos;
    end

    // blend lane setup
    always_comb begin
        sx_full  = {i_in.accel_x, 16'h0000};
        sy_full  = {i_in.accel_y, 16'h0000};
        dx       = tilt ? DIFF_W'(r_avg_x) - DIFF_W'(sx_full)
                        : DIFF_W'(r_cam) - DIFF_W'(heading_keys);
        dy       = DIFF_W'(r_avg_y) - DIFF_W'(sy_full);
        keep_sel = tilt ? r_akeep : r_ckeep;
        bx_start = tick_acc && (!tilt || r_seeded);
        by_start = tick_acc && tilt && r_seeded;
    end

    tthe_blend u_blend_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bx_start),
        .i_diff  (dx),
        .i_keep  (keep_sel),
        .o_done  (bx_done),
        .o_frac  (hx)
    );

    tthe_blend u_blend_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (by_start),
        .i_diff  (dy),
        .i_keep  (keep_sel),
        .o_done  (by_done),
        .o_frac  (hy)
    );

    // blend target plus scaled difference
    always_comb begin
        new_avg_x = ANGLE_W'(FRAC_W'(r_avg_x) + hx);
        new_avg_y = ANGLE_W'(FRAC_W'(r_avg_y) + hy);
        new_cam   = ANGLE_W'(FRAC_W'(r_heading) + hx);
        // targets were taken into r_avg at accept, see below
    end

    // CORDIC start: straight from samples on the seeding tick, else new averages
    always_comb begin
        c_start = (tick_acc && tilt && !r_seeded) ||
                  (r_state == ST_BLEND && bx_done && r_tilt);
        c_x     = (r_state == ST_BLEND) ? new_avg_x : sx_full;
        c_y     = (r_state == ST_BLEND) ? new_avg_y : sy_full;
    end

    tthe_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_x     (c_x),
        .i_y     (c_y),
        .o_done  (c_done),
        .o_angle (c_angle)
    );

    // control, configuration and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_KEYS;
            r_thr       <= THR_W'(25);
            r_akeep     <= KEEP_W'(58982);
            r_ckeep     <= KEEP_W'(52429);
            r_left      <= 1'b0;
            r_right     <= 1'b0;
            r_seeded    <= 1'b0;
            r_tilt      <= 1'b0;
            r_avg_x     <= '0;
            r_avg_y     <= '0;
            r_heading   <= '0;
            r_cam       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STEER_MODE:      r_mode  <= i_cfg_data[MODE_W-1:0];
                    CFG_TOUCH_THRESHOLD: r_thr   <= i_cfg_data[THR_W-1:0];
                    CFG_ACCEL_KEEP:      r_akeep <= i_cfg_data;
                    CFG_CAMERA_KEEP:     r_ckeep <= i_cfg_data;
                    default: ;
                endcase
            end

            // drained word; the finish state reloads it in the same cycle
            if (r_out_valid && o_out.ready && r_state != ST_FINISH)
                r_out_valid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (ptr_acc && r_mode == MODE_TOUCH) begin
                        if (r_left) begin
                            if (i_in.pointer_action == ACT_UP || px > thr_neg)
                                r_left <= 1'b0;
                        end else if (i_in.pointer_action == ACT_DOWN && px < thr_neg) begin
                            r_left <= 1'b1;
                        end
                        if (r_right) begin
                            if (i_in.pointer_action == ACT_UP || px < thr_pos)
                                r_right <= 1'b0;
                        end else if (i_in.pointer_action == ACT_DOWN && px > thr_pos) begin
                            r_right <= 1'b1;
                        end
                    end
                    if (tick_acc) begin
                        r_tilt <= tilt;
                        if (tilt) begin
                            // averages hold the targets while the lanes run
                            r_avg_x <= sx_full;
                            r_avg_y <= sy_full;
                            if (r_seeded) begin
                                r_state <= ST_BLEND;
                            end else begin
                                r_seeded <= 1'b1;
                                r_state  <= ST_CORDIC;
                            end
                        end else begin
                            r_heading <= heading_keys;
                            r_state   <= ST_BLEND;
                        end
                    end
                end
                ST_BLEND: begin
                    if (bx_done) begin
                        if (r_tilt) begin
                            r_avg_x <= new_avg_x;
                            r_avg_y <= new_avg_y;
                            r_state <= ST_CORDIC;
                        end else begin
                            r_cam   <= new_cam;
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_CORDIC: begin
                    if (c_done) begin
                        r_heading <= c_angle - QUARTER_TURN;
                        r_state   <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH && out_free) begin
            r_out_heading <= r_heading;
            r_out_cam     <= r_tilt ? '0 : r_cam;
            r_out_cv      <= !r_tilt;
        end
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.heading       = r_out_heading;
    assign o_out.camera_angle  = r_out_cam;
    assign o_out.camera_valid  = r_out_cv;

    // checks
    a_blend_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bx_done |-> (r_state == ST_BLEND)) else $error("blend done outside blend state");
    a_lanes_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        by_done |-> bx_done) else $error("blend lanes out of step");
    a_cordic_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_done |-> (r_state == ST_CORDIC)) else $error("cordic done outside cordic state");
    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && !r_out_valid) |=> r_out_valid)
        else $error("finished word not loaded");
    a_seed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_seeded)) else $error("seed flag dropped");

endmodule

// ===== hdl/tthe_blend.sv =====
// Bit-serial exponential blend lane: o_frac = floor(i_diff * i_keep / 2^16),
// one keep bit per cycle, LSB first, arithmetic right shift each step.
module tthe_blend (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [tthe_pkg::DIFF_W-1:0]  i_diff,
    input  logic [tthe_pkg::KEEP_W-1:0]         i_keep,
    output logic                                o_done,
    output logic signed [tthe_pkg::FRAC_W-1:0]  o_frac
);
    import tthe_pkg::*;

    logic signed [DIFF_W-1:0] r_d;
    logic [KEEP_W-1:0]        r_k;
    logic signed [FRAC_W-1:0] r_h, n_h;
    logic [KCNT_W-1:0]        r_cnt;
    logic                     r_busy;
    logic                     r_done;

    // one shift-add step
    always_comb begin
        n_h = r_h + (r_k[0] ? FRAC_W'(r_d) : FRAC_W'(0));
        n_h = n_h >>> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= KCNT_W'(KEEP_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == KCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d <= i_diff;
            r_k <= i_keep;
            r_h <= '0;
        end else if (r_busy) begin
            r_k <= r_k >> 1;
            r_h <= n_h;
        end
    end

    assign o_done = r_done;
    assign o_frac = r_h;

endmodule

// ===== hdl/tthe_cordic.sv =====
// Iterative CORDIC atan2 in vectoring mode, one micro-rotation per cycle.
// o_angle is in 2^-16 turn, rounded half up; zero vector gives zero.
module tthe_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [tthe_pkg::ANGLE_W-1:0] i_x,
    input  logic signed [tthe_pkg::ANGLE_W-1:0] i_y,
    output logic                                o_done,
    output logic signed [tthe_pkg::ANGLE_W-1:0] o_angle
);
    import tthe_pkg::*;

    logic signed [CORDIC_W-1:0] r_x, r_y, r_z;
    logic signed [CORDIC_W-1:0] xs, ys, at, zr;
    logic [CCNT_W-1:0]          r_i;
    logic                       r_busy, r_done, r_zero;

    localparam logic signed [CORDIC_W-1:0] HALF_TURN = CORDIC_W'(64'sd2147483648);
    localparam logic signed [CORDIC_W-1:0] ROUND_ADD = CORDIC_W'(32768);

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        at = CORDIC_W'(atan_turn(r_i));
        zr = (r_z + ROUND_ADD) >>> 16;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == CCNT_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // pre-rotation by a half turn for the left half plane, then micro-rotations
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x <= -CORDIC_W'(i_x);
                r_y <= -CORDIC_W'(i_y);
                r_z <= (i_y >= 0) ? HALF_TURN : -HALF_TURN;
            end else begin
                r_x <= CORDIC_W'(i_x);
                r_y <= CORDIC_W'(i_y);
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_zero ? '0 : ANGLE_W'(zr);

endmodule

// ===== test/tb_tthe_if.sv =====
`timescale 1ns / 1ps

// Testbench-side copies are not needed; the RTL interfaces are used directly.
// This file carries the word record types used by the testbench.
package tb_tthe_types;
    typedef struct packed {
        logic        func;
        logic [1:0]  pointer_action;
        logic [15:0] pointer_x;
        logic [15:0] accel_x;
        logic [15:0] accel_y;
        logic [15:0] tick_time;
        logic        key_left;
        logic        key_right;
    } t_steer_word;

    typedef struct packed {
        logic [31:0] heading;
        logic [31:0] camera_angle;
        logic        camera_valid;
    } t_heading_word;
endpackage

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tthe_pkg::*;
    import tb_tthe_types::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [KEEP_W-1:0] i_cfg_data;

    tthe_in_if  in_ch();
    tthe_out_if out_ch();

    tilt_touch_heading_estimator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // predictor state
    logic [1:0]  mode_q;
    logic [14:0] thr_q;
    logic [15:0] akeep_q;
    logic [15:0] ckeep_q;
    logic        left_flag, right_flag, seeded;
    longint      avg_x, avg_y, cam_acc;
    logic [31:0] head_acc;

    t_steer_word   pending_words[$];
    t_heading_word expected_words[$];
    int n_words_sent, n_results, n_fail, n_tilt, n_keys;
    int gap_left, stall_left, hold_off;
    bit hold_req;
    bit in_taken;
    longint cycles;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint ema(longint acc, longint tgt, logic [15:0] keep);
        return floor_sh(acc * longint'(keep) + tgt * (65536 - longint'(keep)), 16);
    endfunction

    // own arctangent table, 2^-32 turn
    function automatic logic [31:0] atan_const(int i);
        logic [31:0] t [0:15];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
              32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
              32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
              32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
        return t[i];
    endfunction

    function automatic longint atan2_turns(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = floor_sh(x, i);
            ys = floor_sh(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += longint'(atan_const(i));
            end else begin
                x -= ys; y += xs; z -= longint'(atan_const(i));
            end
        end
        return floor_sh(z + 32768, 16);
    endfunction

    // expected result of one accepted word; pointer words give none
    task automatic predict_heading(input t_steer_word w);
        longint thr, px;
        logic [31:0] stp;
        t_heading_word r;
        thr = longint'(thr_q);
        px = longint'($signed(w.pointer_x));
        if (w.func == FUNC_POINTER) begin
            if (mode_q == MODE_TOUCH) begin
                if (left_flag) begin
                    if (w.pointer_action == ACT_UP || px > -thr) left_flag = 1'b0;
                end else if (w.pointer_action == ACT_DOWN && px < -thr) left_flag = 1'b1;
                if (right_flag) begin
                    if (w.pointer_action == ACT_UP || px < thr) right_flag = 1'b0;
                end else if (w.pointer_action == ACT_DOWN && px > thr) right_flag = 1'b1;
            end
            return;
        end
        if (mode_q == MODE_TILT) begin
            if (!seeded) begin
                avg_x = longint'($signed(w.accel_x)) * 65536;
                avg_y = longint'($signed(w.accel_y)) * 65536;
                seeded = 1'b1;
            end else begin
                avg_x = ema(avg_x, longint'($signed(w.accel_x)) * 65536, akeep_q);
                avg_y = ema(avg_y, longint'($signed(w.accel_y)) * 65536, akeep_q);
            end
            head_acc = 32'(atan2_turns(avg_y, avg_x) - 16384);
            r = '{head_acc, 32'd0, 1'b0};
            n_tilt++;
        end else begin
            stp = 32'((32'(w.tick_time) + 2) >> 2);
            if (w.key_left || left_flag) head_acc += stp;
            if (w.key_right || right_flag) head_acc -= stp;
            cam_acc = ema(cam_acc, longint'($signed(head_acc)), ckeep_q);
            r = '{head_acc, cam_acc[31:0], 1'b1};
            n_keys++;
        end
        expected_words.push_back(r);
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // accept tracking: predicts at the accepting edge
    always @(posedge i_clk) begin
        in_taken = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_taken) begin
            predict_heading(pending_words.pop_front());
            n_words_sent++;
        end
    end

    // driver: offers pending words
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                in_ch.valid <= 1'b1;
                {in_ch.func, in_ch.pointer_action, in_ch.pointer_x, in_ch.accel_x,
                 in_ch.accel_y, in_ch.tick_time, in_ch.key_left, in_ch.key_right}
                    <= pending_words[0];
                gap_left = gap_len();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_off = 300;
            out_ch.ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off--;
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            stall_left = gap_len();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_heading_word e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            if (expected_words.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected word: heading %h cam %h", out_ch.heading,
                             out_ch.camera_angle);
            end else begin
                e = expected_words.pop_front();
                if (out_ch.heading !== e.heading || out_ch.camera_angle !== e.camera_angle
                    || out_ch.camera_valid !== e.camera_valid) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch: exp %h %h %b got %h %h %b", e.heading,
                                 e.camera_angle, e.camera_valid, out_ch.heading,
                                 out_ch.camera_angle, out_ch.camera_valid);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d words still expected", expected_words.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_steer_word rand_word(bit tick, int mode);
        t_steer_word w;
        w = t_steer_word'(($bits(t_steer_word))'({$urandom, $urandom, $urandom}));
        w.func = tick;
        if ($urandom_range(0, 3) == 0) w.tick_time = 16'hFFFF;
        if (!tick && $urandom_range(0, 2) != 0)
            w.pointer_x = 16'($signed($urandom_range(0, 120)) - 60);
        if (tick && mode == 2 && $urandom_range(0, 9) == 0) begin
            w.accel_x = '0; w.accel_y = '0;
        end
        return w;
    endfunction

    task automatic cfg_write(input t_cfg_idx idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_STEER_MODE:      mode_q = val[1:0];
            CFG_TOUCH_THRESHOLD: thr_q = val[14:0];
            CFG_ACCEL_KEEP:      akeep_q = val;
            default:             ckeep_q = val;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || in_ch.valid || expected_words.size() != 0)
            @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic push(input t_steer_word w);
        pending_words.push_back(w);
    endtask

    initial begin
        t_steer_word w;
        int m;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = CFG_STEER_MODE; i_cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.func = 1'b0; in_ch.pointer_action = '0;
        in_ch.pointer_x = '0; in_ch.accel_x = '0; in_ch.accel_y = '0;
        in_ch.tick_time = '0; in_ch.key_left = 1'b0; in_ch.key_right = 1'b0;
        out_ch.ready = 1'b0;
        mode_q = MODE_KEYS; thr_q = 25; akeep_q = 58982; ckeep_q = 52429;
        left_flag = 0; right_flag = 0; seeded = 0;
        avg_x = 0; avg_y = 0; cam_acc = 0; head_acc = 0;
        cycles = 0; hold_req = 0; hold_off = 0; gap_left = 0; stall_left = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: keys at reset settings, both keys cancel, extremes of time
        push('{1, 0, 0, 0, 0, 16'hFFFF, 1, 0});
        push('{1, 0, 0, 0, 0, 16'h0000, 0, 1});
        push('{1, 0, 0, 0, 0, 16'hFFFF, 1, 1});
        push('{0, ACT_DOWN, -16'sd1000, 0, 0, 0, 0, 0});
        push('{1, 0, 0, 0, 0, 16'h1234, 0, 0});
        drain();
        // touch zones, up, move, action three, extreme positions
        cfg_write(CFG_STEER_MODE, 16'(MODE_TOUCH));
        cfg_write(CFG_CAMERA_KEEP, 16'hFFFF);
        push('{0, ACT_DOWN, 16'h8000, 0, 0, 0, 0, 0});
        push('{0, ACT_DOWN, 16'h7FFF, 0, 0, 0, 0, 0});
        push('{1, 0, 0, 0, 0, 16'h8000, 0, 0});
        push('{0, ACT_MOVE, -16'sd10, 0, 0, 0, 0, 0});
        push('{0, ACT_DOWN, 16'd100, 0, 0, 0, 0, 0});
        push('{0, 2'd3, 16'd100, 0, 0, 0, 0, 0});
        push('{0, ACT_UP, 16'd100, 0, 0, 0, 0, 0});
        push('{1, 0, 0, 0, 0, 16'd400, 0, 0});
        push('{0, ACT_DOWN, 16'h8000, 0, 0, 0, 0, 0});
        drain();
        // flags kept outside touch mode, mode three, maximum threshold
        cfg_write(CFG_STEER_MODE, 16'd3);
        cfg_write(CFG_TOUCH_THRESHOLD, 16'h7FFF);
        cfg_write(CFG_CAMERA_KEEP, 16'h0000);
        push('{1, 0, 0, 0, 0, 16'd800, 0, 0});
        push('{0, ACT_DOWN, 16'd5000, 0, 0, 0, 0, 0});
        drain();
        // tilt: first tick seeds, zero averages, extremes
        cfg_write(CFG_STEER_MODE, 16'(MODE_TILT));
        cfg_write(CFG_ACCEL_KEEP, 16'h0000);
        push('{1, 0, 0, 16'h0000, 16'h0000, 0, 0, 0});
        push('{1, 0, 0, 16'h8000, 16'h7FFF, 0, 0, 0});
        push('{1, 0, 0, 16'h8000, 16'h8000, 0, 0, 0});
        push('{1, 0, 0, 16'h7FFF, 16'h0000, 0, 0, 0});
        push('{1, 0, 0, 16'h8000, 16'h0000, 0, 0, 0});
        drain();

        // random phases through several settings
        for (int ph = 0; ph < 12; ph++) begin
            m = ph % 3;
            cfg_write(CFG_STEER_MODE, 16'(m));
            cfg_write(CFG_TOUCH_THRESHOLD, (ph == 4) ? 16'd0 : 16'($urandom_range(0, 60)));
            cfg_write(CFG_ACCEL_KEEP, (ph == 5) ? 16'hFFFF : 16'($urandom));
            cfg_write(CFG_CAMERA_KEEP, (ph == 7) ? 16'h0000 : 16'($urandom));
            if (ph == 3) hold_req = 1'b1;
            for (int k = 0; k < 100; k++) begin
                w = rand_word(m == 1 ? ($urandom_range(0, 1) == 1) : 1'b1, m);
                if (m != 1 && $urandom_range(0, 9) == 0) w.func = 1'b0;
                push(w);
            end
            drain();
        end

        $display("covered %0d key/touch ticks and %0d tilt ticks, %0d words in total",
                 n_keys, n_tilt, n_words_sent);
        if (n_fail == 0 && expected_words.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/tthe_pkg.sv
hdl/tthe_if.sv
hdl/tthe_blend.sv
hdl/tthe_cordic.sv
hdl/tilt_touch_heading_estimator.sv
test/tb_tthe_if.sv
test/tb.sv
